/* rtl/qsl_pkg.sv */
package qsl_pkg;

	// fixed point format
	localparam int FRAC_BITS  = 30;
	localparam int PROD_SHIFT = 2 * FRAC_BITS - 30;

	// pipeline geometry
	localparam int SQ_CELLS  = 31;
	localparam int DIV_BITS  = 42;

	// angle constants, Q.30
	localparam logic signed [35:0] PI_Q      = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q  = 36'sd6746518852;
	localparam logic signed [35:0] HALF_PI_Q = 36'sd1686629713;
	localparam logic signed [33:0] GAIN_INV_Q = 34'sd652032874;
	localparam logic [31:0]        PI_U      = 32'd3373259426;

	// one and epsilon, Q.30
	localparam logic signed [36:0] QONE_Q = 37'sd1073741824;
	localparam logic signed [36:0] EPS_Q  = 37'sd1074;

	// data carried alongside the arithmetic chains
	typedef struct packed {
		logic [31:0]       alpha;
		logic [3:0][31:0]  a;
		logic [3:0][31:0]  b;
		logic [3:0]        spin;
		logic              flip;
		logic              lin;
		logic [32:0]       spin_rad;
		logic [29:0]       d30;
		logic [30:0]       st;
		logic [31:0]       theta;
		logic              sgn_a;
		logic              sgn_b;
	} side_t;

	typedef struct packed {
		logic [60:0] v;
		logic [61:0] res;
	} sqrt_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} cordic_t;

	typedef struct packed {
		logic [61:0]         rem;
		logic [DIV_BITS-1:0] q;
	} div_t;

	// arctangent of 2^-i, Q.30
	function automatic logic signed [33:0] atan_q(input int i);
		logic signed [33:0] r;
		case (i)
			0: r = 34'sd843314856;
			1: r = 34'sd497837829;
			2: r = 34'sd263043836;
			3: r = 34'sd133525158;
			4: r = 34'sd67021686;
			5: r = 34'sd33543515;
			6: r = 34'sd16775850;
			7: r = 34'sd8388437;
			8: r = 34'sd4194282;
			9: r = 34'sd2097149;
			default: begin
				if (i <= 30) r = $signed(34'((64'd1 << (30 - i)) - 64'd1));
				else r = '0;
			end
		endcase
		return r;
	endfunction

endpackage

/* rtl/qsl_sqrt_cell.sv */
module qsl_sqrt_cell import qsl_pkg::*; #(
	parameter int K = 0
) (
	input  logic  clk,
	input  logic  en,
	input  sqrt_t d,
	output sqrt_t q
);

	localparam logic [61:0] BIT = 62'd1 << (2 * K);

	logic [61:0] t;
	logic        ge;

	// trial subtract for one root bit
	always_comb begin
		t  = d.res + BIT;
		ge = 62'(d.v) >= t;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ge) begin
				q.v   <= d.v - t[60:0];
				q.res <= (d.res >> 1) + BIT;
			end else begin
				q.v   <= d.v;
				q.res <= d.res >> 1;
			end
		end
	end

endmodule

/* rtl/qsl_cordic_cell.sv */
module qsl_cordic_cell import qsl_pkg::*; #(
	parameter int I      = 0,
	parameter bit VECTOR = 1'b0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t d,
	output cordic_t q
);

	logic signed [33:0] xs, ys, at;
	logic               r;

	// micro-rotation direction: vectoring drives y to zero, rotation drives z to zero
	always_comb begin
		xs = $signed(d.x) >>> I;
		ys = $signed(d.y) >>> I;
		at = atan_q(I);
		r  = VECTOR ? !d.y[33] : d.z[33];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (r) begin
				q.x <= d.x + ys;
				q.y <= d.y - xs;
				q.z <= d.z + at;
			end else begin
				q.x <= d.x - ys;
				q.y <= d.y + xs;
				q.z <= d.z - at;
			end
		end
	end

endmodule

/* rtl/qsl_div_cell.sv */
module qsl_div_cell import qsl_pkg::*; #(
	parameter int K = 0
) (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] st,
	input  div_t        d,
	output div_t        q
);

	logic [72:0]         dv;
	logic                ge;
	logic [DIV_BITS-1:0] qn;

	// restoring step for quotient bit K
	always_comb begin
		dv    = 73'(st) << K;
		ge    = 73'(d.rem) >= dv;
		qn    = d.q;
		qn[K] = ge;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.rem <= ge ? d.rem - dv[61:0] : d.rem;
			q.q   <= qn;
		end
	end

endmodule

/* rtl/quaternion_slerp_with_spin.sv */
// Quaternion slerp with extra half turns. One request per cycle is taken while s_tready
// is high. Each request passes through a chain of cells: 31 square-root cells, two CORDIC
// rows of CORDIC_STAGES cells and 42 divider cells, plus multiply stages. Requests are
// independent and flow through back to back. A two-entry output stage lets the input
// side keep going while a result waits, until a second result arrives; s_tready drops
// only when both entries are full.
module quaternion_slerp_with_spin import qsl_pkg::*; #(
	parameter int CORDIC_STAGES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [295:0] s_tdata,  // alpha, a_comp0..3, b_comp0..3, spin_count, zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // r_comp0, r_comp1, r_comp2, r_comp3
	output logic [0:0]   m_tuser   // linear_path
);

	localparam int CS = CORDIC_STAGES;

	logic en;
	logic skid_v_q, out_v_q;
	logic [127:0] out_data_q, skid_data_q;
	logic out_lin_q, skid_lin_q;

	side_t side_in;
	logic  v_s1, v_s2, v_s3;
	side_t side_s1, side_s2, side_s3;
	side_t side_s3_c;
	logic signed [33:0] prod_s2 [4];
	logic [30:0] ah_s2;

	logic signed [35:0] dot_c, dabs_c;
	logic signed [36:0] gap_c;
	logic signed [35:0] ahp_c;
	logic [63:0] srp_c;
	logic signed [63:0] pk_c [4];

	sqrt_t sq_d [SQ_CELLS+1];
	side_t sq_side [SQ_CELLS+1];
	logic  sq_v [SQ_CELLS+1];

	cordic_t vc_d [CS+1];
	side_t vc_side [CS+1];
	logic  vc_v [CS+1];
	side_t vc_side0_c;

	logic v_s4, v_s5, v_s6;
	side_t side_s4, side_s5, side_s6;
	side_t side_s4_c;
	logic signed [63:0] atp_s4;
	logic signed [35:0] ang_b_s5, ang_b_s6, ang_a_s6;
	logic signed [31:0] theta_c;
	logic signed [35:0] sum_c, dif_c;

	cordic_t ra_d [CS+1];
	cordic_t rb_d [CS+1];
	side_t rt_side [CS+1];
	logic  rt_v [CS+1];

	div_t  da_d [DIV_BITS+1];
	div_t  db_d [DIV_BITS+1];
	side_t dv_side [DIV_BITS+1];
	logic  dv_v [DIV_BITS+1];
	side_t dv_side0_c;
	logic [33:0] mag_a_c, mag_b_c;

	logic v_s7, v_s8, v_s9, v_s10;
	side_t side_s7;
	logic signed [43:0] wa_s7, wb_s7;
	logic signed [43:0] wa_c, wb_c;
	logic lin_s8, lin_s9, lin_s10;
	logic signed [54:0] pal_s8 [4], pbl_s8 [4];
	logic signed [53:0] pah_s8 [4], pbh_s8 [4];
	logic signed [77:0] sum_s9 [4];
	logic [3:0][31:0] r_s10;
	logic signed [47:0] sh_c [4];

	// fold an angle in [0, 2pi) into [-pi/2, pi/2] keeping its sine
	function automatic logic signed [33:0] fold(input logic signed [35:0] z);
		logic signed [35:0] t;
		t = (z > PI_Q) ? z - TWO_PI_Q : z;
		if (t > HALF_PI_Q) t = PI_Q - t;
		else if (t < -HALF_PI_Q) t = -PI_Q - t;
		return t[33:0];
	endfunction

	// pipeline advances unless the output stage is full
	assign en       = !skid_v_q;
	assign s_tready = en;

	// unpack request
	always_comb begin
		side_in       = '0;
		side_in.alpha = s_tdata[31:0];
		for (int k = 0; k < 4; k++) begin
			side_in.a[k] = s_tdata[32 + 32*k +: 32];
			side_in.b[k] = s_tdata[160 + 32*k +: 32];
		end
		side_in.spin = s_tdata[291:288];
	end

	// stage valids ahead of the chains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// products of components and alpha times spin
	always_comb begin
		for (int k = 0; k < 4; k++)
			pk_c[k] = $signed(side_s1.a[k]) * $signed(side_s1.b[k]);
		ahp_c = $signed(side_s1.alpha) * $signed(side_s1.spin);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			for (int k = 0; k < 4; k++)
				prod_s2[k] <= 34'(pk_c[k] >>> PROD_SHIFT);
			ah_s2 <= ahp_c[FRAC_BITS:0];
		end
	end

	// dot product, hemisphere flip, linear test, spin angle
	always_comb begin
		dot_c  = 36'(prod_s2[0]) + 36'(prod_s2[1]) + 36'(prod_s2[2]) + 36'(prod_s2[3]);
		dabs_c = dot_c[35] ? -dot_c : dot_c;
		gap_c  = QONE_Q - 37'(dabs_c);
		srp_c  = 64'(ah_s2) * 64'(PI_U);
		side_s3_c          = side_s2;
		side_s3_c.flip     = dot_c[35];
		side_s3_c.lin      = gap_c < EPS_Q;
		side_s3_c.d30      = dabs_c[29:0];
		side_s3_c.spin_rad = srp_c[62:30];
	end

	always_ff @(posedge clk) begin
		if (en) side_s3 <= side_s3_c;
	end

	// square root chain: head forms 1 - cos^2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v[0] <= 1'b0;
		else if (en) sq_v[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side[0] <= side_s3;
			sq_d[0].v   <= (61'd1 << 60) - 61'(side_s3.d30 * side_s3.d30);
			sq_d[0].res <= '0;
		end
	end

	for (genvar j = 0; j < SQ_CELLS; j++) begin : g_sq
		qsl_sqrt_cell #(.K(SQ_CELLS - 1 - j)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq_d[j]),
			.q   (sq_d[j+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[j+1] <= 1'b0;
			else if (en) sq_v[j+1] <= sq_v[j];
		end

		always_ff @(posedge clk) begin
			if (en) sq_side[j+1] <= sq_side[j];
		end
	end

	// vectoring row: angle of (cos, sin)
	always_comb begin
		vc_side0_c    = sq_side[SQ_CELLS];
		vc_side0_c.st = sq_d[SQ_CELLS].res[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc_v[0] <= 1'b0;
		else if (en) vc_v[0] <= sq_v[SQ_CELLS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vc_side[0]    <= vc_side0_c;
			vc_d[0].x     <= $signed({4'b0000, sq_side[SQ_CELLS].d30});
			vc_d[0].y     <= $signed({3'b000, sq_d[SQ_CELLS].res[30:0]});
			vc_d[0].z     <= '0;
		end
	end

	for (genvar j = 0; j < CS; j++) begin : g_vc
		qsl_cordic_cell #(.I(j), .VECTOR(1'b1)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (vc_d[j]),
			.q   (vc_d[j+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vc_v[j+1] <= 1'b0;
			else if (en) vc_v[j+1] <= vc_v[j];
		end

		always_ff @(posedge clk) begin
			if (en) vc_side[j+1] <= vc_side[j];
		end
	end

	// target angles: b at alpha*theta plus spin turns, a at theta minus b, both reduced mod 2pi
	always_comb begin
		theta_c = vc_d[CS].z[31:0];
		side_s4_c       = vc_side[CS];
		side_s4_c.theta = theta_c;
		sum_c   = 36'(atp_s4 >>> FRAC_BITS) + $signed({3'b000, side_s4.spin_rad});
		dif_c   = 36'($signed(side_s5.theta)) - ang_b_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= vc_v[CS];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4       <= side_s4_c;
			atp_s4        <= $signed(vc_side[CS].alpha) * theta_c;
			side_s5       <= side_s4;
			if (sum_c < 0) ang_b_s5 <= sum_c + TWO_PI_Q;
			else if (sum_c >= TWO_PI_Q) ang_b_s5 <= sum_c - TWO_PI_Q;
			else ang_b_s5 <= sum_c;
			side_s6  <= side_s5;
			ang_b_s6 <= ang_b_s5;
			ang_a_s6 <= (dif_c < 0) ? dif_c + TWO_PI_Q : dif_c;
		end
	end

	// rotation rows: sines of both angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rt_v[0] <= 1'b0;
		else if (en) rt_v[0] <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_side[0] <= side_s6;
			ra_d[0].x  <= GAIN_INV_Q;
			ra_d[0].y  <= '0;
			ra_d[0].z  <= fold(ang_a_s6);
			rb_d[0].x  <= GAIN_INV_Q;
			rb_d[0].y  <= '0;
			rb_d[0].z  <= fold(ang_b_s6);
		end
	end

	for (genvar j = 0; j < CS; j++) begin : g_rt
		qsl_cordic_cell #(.I(j), .VECTOR(1'b0)) u_cell_a (
			.clk (clk),
			.en  (en),
			.d   (ra_d[j]),
			.q   (ra_d[j+1])
		);

		qsl_cordic_cell #(.I(j), .VECTOR(1'b0)) u_cell_b (
			.clk (clk),
			.en  (en),
			.d   (rb_d[j]),
			.q   (rb_d[j+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v[j+1] <= 1'b0;
			else if (en) rt_v[j+1] <= rt_v[j];
		end

		always_ff @(posedge clk) begin
			if (en) rt_side[j+1] <= rt_side[j];
		end
	end

	// divider rows: sine over sin(theta), magnitude and sign kept apart
	always_comb begin
		mag_a_c = ra_d[CS].y[33] ? 34'(-ra_d[CS].y) : 34'(ra_d[CS].y);
		mag_b_c = rb_d[CS].y[33] ? 34'(-rb_d[CS].y) : 34'(rb_d[CS].y);
		dv_side0_c       = rt_side[CS];
		dv_side0_c.sgn_a = ra_d[CS].y[33];
		dv_side0_c.sgn_b = rb_d[CS].y[33];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v[0] <= 1'b0;
		else if (en) dv_v[0] <= rt_v[CS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side[0]       <= dv_side0_c;
			da_d[0].rem      <= 62'(mag_a_c) << FRAC_BITS;
			da_d[0].q        <= '0;
			db_d[0].rem      <= 62'(mag_b_c) << FRAC_BITS;
			db_d[0].q        <= '0;
		end
	end

	for (genvar j = 0; j < DIV_BITS; j++) begin : g_dv
		qsl_div_cell #(.K(DIV_BITS - 1 - j)) u_cell_a (
			.clk (clk),
			.en  (en),
			.st  (dv_side[j].st),
			.d   (da_d[j]),
			.q   (da_d[j+1])
		);

		qsl_div_cell #(.K(DIV_BITS - 1 - j)) u_cell_b (
			.clk (clk),
			.en  (en),
			.st  (dv_side[j].st),
			.d   (db_d[j]),
			.q   (db_d[j+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[j+1] <= 1'b0;
			else if (en) dv_v[j+1] <= dv_v[j];
		end

		always_ff @(posedge clk) begin
			if (en) dv_side[j+1] <= dv_side[j];
		end
	end

	// weight select: linear or spherical, then hemisphere flip
	always_comb begin
		if (dv_side[DIV_BITS].lin) begin
			wa_c = 44'sd1073741824 - 44'($signed(dv_side[DIV_BITS].alpha));
			wb_c = 44'($signed(dv_side[DIV_BITS].alpha));
		end else begin
			wa_c = $signed({2'b00, da_d[DIV_BITS].q});
			wb_c = $signed({2'b00, db_d[DIV_BITS].q});
			if (dv_side[DIV_BITS].sgn_a) wa_c = -wa_c;
			if (dv_side[DIV_BITS].sgn_b) wb_c = -wb_c;
		end
		if (dv_side[DIV_BITS].flip) wb_c = -wb_c;
	end

	// output saturation
	always_comb begin
		for (int k = 0; k < 4; k++)
			sh_c[k] = 48'(sum_s9[k] >>> FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s7  <= dv_v[DIV_BITS];
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// weighted sum: weights split into high and low halves for the multipliers
	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= dv_side[DIV_BITS];
			wa_s7   <= wa_c;
			wb_s7   <= wb_c;
			lin_s8  <= side_s7.lin;
			for (int k = 0; k < 4; k++) begin
				pal_s8[k] <= $signed({1'b0, wa_s7[21:0]}) * $signed(side_s7.a[k]);
				pah_s8[k] <= $signed(wa_s7[43:22]) * $signed(side_s7.a[k]);
				pbl_s8[k] <= $signed({1'b0, wb_s7[21:0]}) * $signed(side_s7.b[k]);
				pbh_s8[k] <= $signed(wb_s7[43:22]) * $signed(side_s7.b[k]);
			end
			lin_s9 <= lin_s8;
			for (int k = 0; k < 4; k++)
				sum_s9[k] <= ((78'(pah_s8[k]) + 78'(pbh_s8[k])) <<< 22)
					+ 78'(pal_s8[k]) + 78'(pbl_s8[k]);
			lin_s10 <= lin_s9;
			for (int k = 0; k < 4; k++) begin
				if (sh_c[k] > 48'sd2147483647) r_s10[k] <= 32'h7fff_ffff;
				else if (sh_c[k] < -48'sd2147483648) r_s10[k] <= 32'h8000_0000;
				else r_s10[k] <= sh_c[k][31:0];
			end
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (v_s10) begin
				if (!out_v_q || m_tready) out_v_q <= 1'b1;
				else skid_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end else if (m_tready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (v_s10) begin
				if (!out_v_q || m_tready) begin
					out_data_q <= r_s10;
					out_lin_q  <= lin_s10;
				end else begin
					skid_data_q <= r_s10;
					skid_lin_q  <= lin_s10;
				end
			end
		end else if (m_tready) begin
			out_data_q <= skid_data_q;
			out_lin_q  <= skid_lin_q;
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_lin_q;

endmodule

/* rtl/qsl_checker.sv */
module qsl_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [0:0]   m_tuser
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input side blocks only with a result pending
	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input blocked with empty output");

	// input side blocks only after a stall at the output
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input blocked without output stall");

endmodule

bind quaternion_slerp_with_spin qsl_checker u_qsl_checker (.*);

/* dv/tb_top.sv */
module tb_top;
	import qsl_pkg::*;

	localparam int LATENCY    = 151;
	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		logic [3:0][31:0] comp;
		logic             lin;
	} slerp_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [295:0] s_tdata;   // alpha, a_comp0..3, b_comp0..3, spin_count, zero pad
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // r_comp0, r_comp1, r_comp2, r_comp3
	logic [0:0]   m_tuser;   // linear_path

	slerp_res_t pending_results[$];
	int         fail_count;
	int         sent_count;
	int         recv_count;
	int         lin_count;
	int         burst_left;
	int         idle_cycles;
	int         stall_mode;
	int         stall_phase;

	quaternion_slerp_with_spin dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// arctangent of 2^-i in q.30
	function automatic longint arc_step(input int i);
		longint tbl[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149};
		if (i < 10) return tbl[i];
		if (i <= 30) return (longint'(1) << (30 - i)) - 1;
		return 0;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// vectoring: angle of (x, y)
	function automatic longint vector_angle(input longint x, input longint y);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arc_step(i);
			end else begin
				x -= dx; y += dy; z -= arc_step(i);
			end
		end
		return z;
	endfunction

	// rotation: sine of an angle in [0, 2pi)
	function automatic longint rot_sine(input longint z);
		longint x, y, dx, dy;
		x = 652032874;
		y = 0;
		if (z > 64'sd3373259426) z -= 64'sd6746518852;
		if (z > 64'sd1686629713) z = 64'sd3373259426 - z;
		else if (z < -64'sd1686629713) z = -64'sd3373259426 - z;
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_step(i);
			end else begin
				x += dx; y -= dy; z += arc_step(i);
			end
		end
		return y;
	endfunction

	function automatic longint wrap_turn(input longint x);
		longint r;
		r = x % 64'sd6746518852;
		return (r < 0) ? r + 64'sd6746518852 : r;
	endfunction

	// weighted sum, shifted and saturated
	function automatic logic [31:0] blend_comp(input longint wa, input longint ca,
			input longint wb, input longint cb);
		logic signed [127:0] wa_w, ca_w, wb_w, cb_w, acc;
		wa_w = wa; ca_w = ca; wb_w = wb; cb_w = cb;
		acc = (wa_w * ca_w + wb_w * cb_w) >>> 30;
		if (acc > 128'sd2147483647) return 32'h7FFFFFFF;
		if (acc < -128'sd2147483648) return 32'h80000000;
		return acc[31:0];
	endfunction

	function automatic slerp_res_t slerp_predict(input logic [295:0] d);
		slerp_res_t r;
		longint alpha, spin, dot, wa, wb, st, theta, ang_a, ang_b;
		longint qa[4], qb[4];
		longint unsigned h, spin_rad;
		logic flip;
		alpha = longint'($signed(d[31:0]));
		spin = longint'($signed(d[291:288]));
		dot = 0;
		for (int k = 0; k < 4; k++) begin
			qa[k] = longint'($signed(d[32 + 32 * k +: 32]));
			qb[k] = longint'($signed(d[160 + 32 * k +: 32]));
			dot += (qa[k] * qb[k]) >>> 30;
		end
		flip = dot < 0;
		if (flip) dot = -dot;
		r.lin = ((64'sd1073741824 - dot) < 64'sd1074);
		if (r.lin) begin
			wa = 64'sd1073741824 - alpha;
			wb = alpha;
		end else begin
			st = longint'(int_sqrt(64'd1152921504606846976 -
				longint'(unsigned'(dot)) * longint'(unsigned'(dot))));
			theta = vector_angle(dot, st);
			h = longint'(unsigned'(alpha * spin)) & 64'h7FFFFFFF;
			spin_rad = (h * 64'd3373259426) >> 30;
			ang_b = wrap_turn(((alpha * theta) >>> 30) + longint'(spin_rad));
			ang_a = wrap_turn(theta - ang_b);
			wa = (rot_sine(ang_a) * 64'sd1073741824) / st;
			wb = (rot_sine(ang_b) * 64'sd1073741824) / st;
		end
		if (flip) wb = -wb;
		for (int k = 0; k < 4; k++) r.comp[k] = blend_comp(wa, qa[k], wb, qb[k]);
		return r;
	endfunction

	// expected results are recorded as requests are taken
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			pending_results.push_back(slerp_predict(s_tdata));
			sent_count++;
		end
	end

	// result checker
	always @(posedge clk) begin
		slerp_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			recv_count++;
			if (pending_results.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (exp_r.lin) lin_count++;
				for (int k = 0; k < 4; k++) begin
					if (m_tdata[32 * k +: 32] !== exp_r.comp[k]) begin
						$error("r_comp%0d expected %h actual %h", k, exp_r.comp[k],
							m_tdata[32 * k +: 32]);
						fail_count++;
					end
				end
				if (m_tuser[0] !== exp_r.lin) begin
					$error("linear_path expected %b actual %b", exp_r.lin, m_tuser[0]);
					fail_count++;
				end
			end
		end
	end

	// receiver stall pattern: free, light random, or long stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			stall_phase++;
			if (stall_phase >= 97) begin
				stall_phase = 0;
				stall_mode = $urandom_range(0, 2);
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ((stall_phase % 23) > 14);
			endcase
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding",
				pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// send one request, in bursts with random gaps
	task automatic send_request(input logic [31:0] alpha, input logic [3:0][31:0] qa,
			input logic [3:0][31:0] qb, input logic [3:0] spin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 16);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, spin, qb, qa, alpha};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [31:0] near_unit();
		return $signed($urandom) >>> 2;
	endfunction

	task automatic test_extremes();
		logic [31:0] edges[4] = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h40000000};
		logic [3:0][31:0] qa, qb;
		for (int i = 0; i < 4; i++) begin
			for (int k = 0; k < 4; k++) begin
				qa[k] = edges[(i + k) % 4];
				qb[k] = edges[(i + 3 * k) % 4];
			end
			send_request(edges[i], qa, qb, 4'(i * 5));
		end
		qa = {4{32'hFFFFFFFF}};
		qb = {4{32'h7FFFFFFF}};
		send_request(32'hFFFFFFFF, qa, qb, 4'b1000);
	endtask

	task automatic test_near_identical();
		logic [3:0][31:0] qa;
		qa = {32'h0, 32'h0, 32'h0, 32'h40000000};
		send_request(32'h20000000, qa, qa, 4'd3);
		send_request(32'h7FFFFFFF, qa, qa, 4'd7);
		// cosine above one from unnormalised inputs
		send_request(32'h10000000, {4{32'h30000000}}, {4{32'h30000000}}, 4'd1);
	endtask

	task automatic test_opposite_hemisphere();
		logic [3:0][31:0] qa, qb;
		qa = {32'h0, 32'h0, 32'h0, 32'h40000000};
		qb = {32'h0, 32'h0, 32'h0, 32'hC0000000};
		send_request(32'h20000000, qa, qb, 4'd0);
		qb = {32'h0, 32'h0, 32'h2D413CCD, 32'hD2BEC333};
		send_request(32'h15555555, qa, qb, 4'd2);
	endtask

	task automatic test_spins();
		logic [3:0][31:0] qa, qb;
		qa = {32'h0, 32'h0, 32'h0, 32'h40000000};
		qb = {32'h0, 32'h0, 32'h2D413CCD, 32'h2D413CCD};
		for (int s = 0; s < 16; s++) send_request(32'h0C000000 + 32'(s << 24), qa, qb, 4'(s));
		send_request(32'hE0000000, qa, qb, 4'd5);
	endtask

	task automatic test_random(input int n);
		logic [3:0][31:0] qa, qb;
		logic [31:0] alpha;
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 99);
			for (int k = 0; k < 4; k++) qa[k] = near_unit();
			alpha = $urandom_range(0, 32'h40000000);
			if (kind < 15) begin
				for (int k = 0; k < 4; k++) begin
					qa[k] = $urandom;
					qb[k] = $urandom;
				end
				alpha = $urandom;
			end else if (kind < 35) begin
				for (int k = 0; k < 4; k++) qb[k] = qa[k] + ($signed($urandom) >>> 24);
			end else if (kind < 50) begin
				for (int k = 0; k < 4; k++) qb[k] = -qa[k] + ($signed($urandom) >>> 20);
			end else begin
				for (int k = 0; k < 4; k++) qb[k] = near_unit();
			end
			send_request(alpha, qa, qb, 4'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		fail_count = 0;
		sent_count = 0;
		recv_count = 0;
		lin_count = 0;
		burst_left = 0;
		idle_cycles = 0;
		stall_mode = 0;
		stall_phase = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_near_identical();
		test_opposite_hemisphere();
		test_spins();
		test_random(1000);

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 50) @(posedge clk);

		$display("covered %0d requests and %0d results, %0d on the linear path",
			sent_count, recv_count, lin_count);
		$display("edges, near-identical and opposite inputs, all spin counts, random");
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
